FILE: rtl/siph_pkg.sv
`timescale 1ns / 1ps
// Package for the keyed SipHash core: lane types, initialization constants,
// sequencer states, register indexes and round-count helpers.
// No dependencies.
package siph_pkg;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } lanes_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND_C,
        ST_FIN_LOAD,
        ST_ROUND_D,
        ST_EMIT
    } state_t;

    localparam logic [63:0] IV_A = 64'h736f6d6570736575;
    localparam logic [63:0] IV_B = 64'h646f72616e646f6d;
    localparam logic [63:0] IV_C = 64'h6c7967656e657261;
    localparam logic [63:0] IV_D = 64'h7465646279746573;
    localparam logic [63:0] FINAL_MARK = 64'h00000000000000ff;

    localparam int ROT_B0 = 13;
    localparam int ROT_D0 = 16;
    localparam int ROT_D1 = 21;
    localparam int ROT_B1 = 17;
    localparam int ROT_HALF = 32;

    // Configuration register indexes.
    localparam logic [1:0] REG_KEY_LOW = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_VARIANT = 2'd2;

    // Round variant codes.
    localparam logic [1:0] VAR_1_3 = 2'd0;
    localparam logic [1:0] VAR_2_4 = 2'd1;
    localparam logic [1:0] VAR_4_8 = 2'd2;

    localparam logic [3:0] FULL_BYTES = 4'd8;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    // Index of the last compression round for a variant.
    function automatic logic [2:0] c_last(input logic [1:0] variant);
        logic [2:0] n;
        unique case (variant)
            VAR_1_3: n = 3'd0;
            VAR_4_8: n = 3'd3;
            default: n = 3'd1;
        endcase
        return n;
    endfunction

    // Index of the last finalization round for a variant.
    function automatic logic [2:0] d_last(input logic [1:0] variant);
        logic [2:0] n;
        unique case (variant)
            VAR_1_3: n = 3'd2;
            VAR_4_8: n = 3'd7;
            default: n = 3'd3;
        endcase
        return n;
    endfunction

    function automatic lanes_t load_lanes(input logic [63:0] k0, input logic [63:0] k1);
        lanes_t l;
        l.a = k0 ^ IV_A;
        l.b = k1 ^ IV_B;
        l.c = k0 ^ IV_C;
        l.d = k1 ^ IV_D;
        return l;
    endfunction

endpackage

FILE: rtl/siph_round.sv
`timescale 1ns / 1ps
// One SipRound over the four lanes, shared by every compression and
// finalization step. Depends on siph_pkg.
module siph_round (
    input  siph_pkg::lanes_t lanes_in,
    output siph_pkg::lanes_t lanes_out
);
    import siph_pkg::*;

    logic [63:0] a1;
    logic [63:0] b1;
    logic [63:0] c1;
    logic [63:0] d1;
    logic [63:0] a2;
    logic [63:0] a3;
    logic [63:0] d2;
    logic [63:0] c2;
    logic [63:0] b2;

    // The two halves of each step are independent, so the add depth is two.
    assign a1 = lanes_in.a + lanes_in.b;
    assign b1 = rotl64(lanes_in.b, ROT_B0) ^ a1;
    assign a2 = rotl64(a1, ROT_HALF);
    assign c1 = lanes_in.c + lanes_in.d;
    assign d1 = rotl64(lanes_in.d, ROT_D0) ^ c1;
    assign a3 = a2 + d1;
    assign d2 = rotl64(d1, ROT_D1) ^ a3;
    assign c2 = c1 + b1;
    assign b2 = rotl64(b1, ROT_B1) ^ c2;

    assign lanes_out.a = a3;
    assign lanes_out.b = b2;
    assign lanes_out.c = rotl64(c2, ROT_HALF);
    assign lanes_out.d = d2;

endmodule

FILE: rtl/siphash_keyed_hash_core.sv
`timescale 1ns / 1ps
// Keyed SipHash core: sequencer, lane registers and configuration.
// Depends on siph_pkg and siph_round.
//
// Usage:
//   The slave stream takes one 64-bit little-endian message word per beat.
//   tdata[63:0] is the word, tdata[67:64] the byte count (read on the last
//   word only, values above 8 count as 8), and tlast marks the final word.
//   The master stream returns one 64-bit hash per message, on its last word.
//   The configuration port writes key_low (0), key_high (1) and the round
//   variant (2: 0 = 1-3, 1 = 2-4, 2 = 4-8); any write reloads the lanes from
//   the key and restarts the message.
// Sequence (c and d are the variant's round counts, one SipRound per cycle in
// the single shared round unit):
//   non-last word          : c rounds, then tready returns
//   last word, < 8 bytes   : c rounds, then d rounds, then the hash beat
//   last word, 8 bytes     : c rounds, length block, c rounds, d rounds, hash beat
//   A new word is accepted only when the sequencer is back in idle.
// Reset loads the lanes from an all-zero key and selects SipHash-2-4.
// When the receiver stalls, the hash waits in the output register; a second
// finished message waits in the sequencer until that register is free.
module siphash_keyed_hash_core (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // Message words in.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // [63:0] message_word, [67:64] byte_count
    input  logic        s_axis_tlast,  // last_word
    // Hash out.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // [63:0] digest
);
    import siph_pkg::*;

    state_t      state_reg;
    state_t      state_next;
    lanes_t      lanes_reg;
    lanes_t      lanes_next;
    lanes_t      round_out;
    logic [63:0] key_low_reg;
    logic [63:0] key_low_next;
    logic [63:0] key_high_reg;
    logic [63:0] key_high_next;
    logic [1:0]  variant_reg;
    logic [1:0]  variant_next;
    logic [7:0]  len_reg;
    logic [7:0]  len_next;
    logic [63:0] msg_reg;
    logic [63:0] msg_next;
    logic        final_reg;
    logic        final_next;
    logic        last_reg;
    logic        last_next;
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;
    logic [63:0] hash_reg;
    logic [63:0] hash_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    logic        in_accept;
    logic        emit_go;
    logic        full_word;
    logic [3:0]  in_count;
    logic [63:0] in_word;
    logic [63:0] tail;
    logic [63:0] in_block;
    logic [7:0]  in_len;
    logic        c_done;
    logic        d_done;

    siph_round u_round (
        .lanes_in  (lanes_reg),
        .lanes_out (round_out)
    );

    assign in_word   = s_axis_tdata[63:0];
    assign in_count  = s_axis_tdata[67:64];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign full_word = !s_axis_tlast || (in_count >= FULL_BYTES);
    assign emit_go   = !out_valid_reg || m_axis_tready;
    assign c_done    = (cnt_reg == c_last(variant_reg));
    assign d_done    = (cnt_reg == d_last(variant_reg));

    // Tail bytes of a short last word: bytes at or above the count drop out.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            tail[8*i +: 8] = (4'(i) < in_count) ? in_word[8*i +: 8] : 8'd0;
        end
    end

    assign in_len   = full_word ? (len_reg + 8'd8) : (len_reg + {4'd0, in_count});
    assign in_block = full_word ? in_word : {in_len, tail[55:0]};

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = hash_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_ROUND_C;
                end
            end
            ST_ROUND_C:
            begin
                if (c_done)
                begin
                    if (final_reg)
                    begin
                        state_next = ST_ROUND_D;
                    end
                    else if (last_reg)
                    begin
                        state_next = ST_FIN_LOAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FIN_LOAD:
            begin
                state_next = ST_ROUND_C;
            end
            ST_ROUND_D:
            begin
                if (d_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        lanes_next     = lanes_reg;
        key_low_next   = key_low_reg;
        key_high_next  = key_high_reg;
        variant_next   = variant_reg;
        len_next       = len_reg;
        msg_next       = msg_reg;
        final_next     = final_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    lanes_next.d = lanes_reg.d ^ in_block;
                    msg_next     = in_block;
                    final_next   = !full_word;
                    last_next    = s_axis_tlast;
                    len_next     = in_len;
                    cnt_next     = 3'd0;
                end
            end
            ST_ROUND_C:
            begin
                lanes_next = round_out;
                cnt_next   = cnt_reg + 3'd1;
                if (c_done)
                begin
                    lanes_next.a = round_out.a ^ msg_reg;
                    if (final_reg)
                    begin
                        lanes_next.c = round_out.c ^ FINAL_MARK;
                    end
                    cnt_next = 3'd0;
                end
            end
            ST_FIN_LOAD:
            begin
                // A full last word leaves an empty tail: the block is the length alone.
                lanes_next.d = lanes_reg.d ^ {len_reg, 56'd0};
                msg_next     = {len_reg, 56'd0};
                final_next   = 1'b1;
            end
            ST_ROUND_D:
            begin
                lanes_next = round_out;
                cnt_next   = cnt_reg + 3'd1;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    hash_next      = lanes_reg.a ^ lanes_reg.b ^ lanes_reg.c ^ lanes_reg.d;
                    out_valid_next = 1'b1;
                    lanes_next     = load_lanes(key_low_reg, key_high_reg);
                    len_next       = 8'd0;
                end
            end
            default:
            begin
                lanes_next = lanes_reg;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_LOW:  key_low_next  = cfg_data;
                REG_KEY_HIGH: key_high_next = cfg_data;
                REG_VARIANT:  variant_next  = cfg_data[1:0];
                default:      variant_next  = variant_reg;
            endcase
            lanes_next = load_lanes(key_low_next, key_high_next);
            len_next   = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lanes_reg     <= load_lanes(64'd0, 64'd0);
            key_low_reg   <= 64'd0;
            key_high_reg  <= 64'd0;
            variant_reg   <= VAR_2_4;
            len_reg       <= 8'd0;
            final_reg     <= 1'b0;
            last_reg      <= 1'b0;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lanes_reg     <= lanes_next;
            key_low_reg   <= key_low_next;
            key_high_reg  <= key_high_next;
            variant_reg   <= variant_next;
            len_reg       <= len_next;
            final_reg     <= final_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_reg  <= msg_next;
        hash_reg <= hash_next;
    end

    // A hash beat only ever appears right after the emit state released it.
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_EMIT))
        else $error("hash beat raised outside the emit state");

    // After a hash is released the lanes hold the key-derived start values.
    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && emit_go && !cfg_we
        |=> (lanes_reg.a == (key_low_reg ^ IV_A)) && (len_reg == 8'd0))
        else $error("lanes not reloaded after hash");

    // In the compression phase the round counter never passes the index of its last round.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND_C) |-> (cnt_reg <= c_last(variant_reg)))
        else $error("compression round counter out of range");

    // Every accepted word starts compression in the next cycle.
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_ROUND_C) && (cnt_reg == 3'd0))
        else $error("accepted word did not start compression");

endmodule

FILE: tb/sv/siphash_keyed_hash_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the keyed SipHash core: directed and random messages
// under several keys and round variants, checked against an in-bench hash predictor.
// Depends on siph_pkg and the siphash_keyed_hash_core RTL.
module siphash_keyed_hash_core_test;
    import siph_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_WORDS = 1800;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam logic [1:0] VAR_SPARE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;  // [63:0] message_word, [67:64] byte_count, [71:68] zero
    logic        s_axis_tlast;  // last_word
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;  // [63:0] digest

    siphash_keyed_hash_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Predictor state: the four lanes, the running length and the configuration.
    logic [63:0] v0, v1, v2, v3;
    logic [7:0]  msg_len;
    logic [63:0] key0, key1;
    logic [1:0]  variant_code;

    logic [63:0] expected_hashes[$];
    logic [63:0] want_hash;
    int          fail_count = 0;
    int          words_sent = 0;
    int          quiet_cycles = 0;
    int          holdoff_request = 0;
    bit          idle_on = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] rol(input logic [63:0] x, input int unsigned r);
        logic [127:0] t;
        t = {x, x} << r;
        return t[127:64];
    endfunction

    function automatic int unsigned compress_rounds();
        case (variant_code)
            VAR_1_3: return 1;
            VAR_4_8: return 4;
            default: return 2;
        endcase
    endfunction

    function automatic int unsigned final_rounds();
        case (variant_code)
            VAR_1_3: return 3;
            VAR_4_8: return 8;
            default: return 4;
        endcase
    endfunction

    task automatic mix_round();
        v0 = v0 + v1; v1 = rol(v1, ROT_B0); v1 = v1 ^ v0; v0 = rol(v0, ROT_HALF);
        v2 = v2 + v3; v3 = rol(v3, ROT_D0); v3 = v3 ^ v2;
        v0 = v0 + v3; v3 = rol(v3, ROT_D1); v3 = v3 ^ v0;
        v2 = v2 + v1; v1 = rol(v1, ROT_B1); v1 = v1 ^ v2; v2 = rol(v2, ROT_HALF);
    endtask

    task automatic compress_block(input logic [63:0] m);
        v3 = v3 ^ m;
        repeat (compress_rounds()) mix_round();
        v0 = v0 ^ m;
    endtask

    task automatic reload_from_key();
        v0 = key0 ^ IV_A;
        v1 = key1 ^ IV_B;
        v2 = key0 ^ IV_C;
        v3 = key1 ^ IV_D;
        msg_len = 8'd0;
    endtask

    // Advances the lanes by one accepted beat; a last word queues its hash.
    task automatic predict_beat(input logic [63:0] word, input logic [3:0] count,
                                input logic last);
        logic [63:0] tail;
        logic [3:0]  n;
        if (!last)
        begin
            compress_block(word);
            msg_len = msg_len + 8'd8;
            return;
        end
        n = (count > FULL_BYTES) ? FULL_BYTES : count;
        if (n == FULL_BYTES)
        begin
            compress_block(word);
            msg_len = msg_len + 8'd8;
            tail = 64'd0;
        end
        else
        begin
            tail = (n == 4'd0) ? 64'd0 : (word & ((64'd1 << (8 * n)) - 64'd1));
            msg_len = msg_len + 8'(n);
        end
        compress_block({msg_len, 56'd0} | tail);
        v2 = v2 ^ FINAL_MARK;
        repeat (final_rounds()) mix_round();
        expected_hashes.push_back(v0 ^ v1 ^ v2 ^ v3);
        reload_from_key();
    endtask

    function automatic logic [63:0] random_word();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] random_key();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_word(input logic [63:0] word, input logic [3:0] count,
                             input logic last);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {4'd0, count, word};
        s_axis_tlast = last;
        do @(posedge clk); while (!s_axis_tready);
        predict_beat(word, count, last);
        words_sent++;
    endtask

    // Full words carry a random byte count, which the block must ignore.
    task automatic send_message(input int unsigned full_words, input logic [3:0] tail_count);
        repeat (full_words) send_word(random_word(), 4'($urandom_range(0, 15)), 1'b0);
        send_word(random_word(), tail_count, 1'b1);
    endtask

    // A non-last word leaves no hash behind, so the settle time covers the
    // rounds that may still be running after the queue has emptied.
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (expected_hashes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [63:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (index == REG_KEY_LOW)
            key0 = value;
        else if (index == REG_KEY_HIGH)
            key1 = value;
        else if (index == REG_VARIANT)
            variant_code = value[1:0];
        reload_from_key();
    endtask

    task automatic test_reset_defaults();
        send_word(random_word(), 4'd0, 1'b1);
        send_word(64'h0706050403020100, 4'd3, 1'b1);
        send_word(64'h0706050403020100, 4'd0, 1'b0);
        send_word(64'h0f0e0d0c0b0a0908, 4'd7, 1'b1);
    endtask

    task automatic test_field_extremes();
        wait_idle();
        write_register(REG_KEY_LOW, 64'h0706050403020100);
        write_register(REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
        send_word('1, 4'd8, 1'b1);
        send_word(64'd0, 4'd8, 1'b1);
        // Bytes at and above the count must not reach the final block.
        send_word('1, 4'd5, 1'b1);
        send_word('1, 4'd15, 1'b1);
        send_word(64'h8000000000000001, 4'd9, 1'b1);
        send_word('1, 4'd15, 1'b0);
        send_word(64'd0, 4'd0, 1'b0);
        send_word(64'h0123456789abcdef, 4'd1, 1'b1);
    endtask

    task automatic test_variants();
        logic [1:0] codes[4];
        codes = '{VAR_1_3, VAR_4_8, VAR_SPARE, VAR_2_4};
        foreach (codes[i])
        begin
            wait_idle();
            write_register(REG_VARIANT, {62'd0, codes[i]});
            send_message(1, 4'd4);
        end
    endtask

    task automatic test_config_abort();
        send_word(random_word(), 4'd8, 1'b0);
        send_word(random_word(), 4'd2, 1'b0);
        wait_idle();
        write_register(REG_SPARE, {$urandom, $urandom});
        send_word(random_word(), 4'd8, 1'b0);
        wait_idle();
        write_register(REG_KEY_LOW, '1);
        send_word(random_word(), 4'd6, 1'b1);
    endtask

    task automatic test_random_messages();
        int stop_at;
        int phase;
        stop_at = words_sent + RANDOM_WORDS;
        phase = 0;
        while (words_sent < stop_at)
        begin
            wait_idle();
            write_register(REG_KEY_LOW, random_key());
            write_register(REG_KEY_HIGH, random_key());
            write_register(REG_VARIANT, {62'd0, 2'(phase % 4)});
            idle_on = (phase % 3) != 2;
            repeat (12)
            begin
                // Long messages can carry the length past 255 bytes.
                if ($urandom_range(0, 9) == 0)
                    send_message($urandom_range(28, 40), 4'($urandom_range(0, 15)));
                else if ($urandom_range(0, 9) < 7)
                    send_message($urandom_range(0, 5), 4'($urandom_range(0, 8)));
                else
                    send_message($urandom_range(0, 5), 4'($urandom_range(9, 15)));
            end
            // Now and then break a message off with a register write.
            if ($urandom_range(0, 3) == 0)
            begin
                send_message(0, 4'd8);
                repeat ($urandom_range(1, 4))
                    send_word(random_word(), 4'($urandom_range(0, 15)), 1'b0);
                wait_idle();
                write_register(2'($urandom_range(0, 3)), random_key());
            end
            phase++;
        end
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        wait_idle();
        write_register(REG_VARIANT, {62'd0, VAR_1_3});
        idle_on = 1'b0;
        holdoff_request = HOLD_OFF_CYCLES;
        repeat (30) send_message($urandom_range(0, 2), 4'($urandom_range(0, 8)));
        idle_on = 1'b1;
    endtask

    // Receiver: random stalls per beat, plus one long hold-off on request.
    initial
    begin
        int unsigned stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holdoff_request != 0)
            begin
                m_axis_tready = 1'b0;
                repeat (holdoff_request) @(negedge clk);
                holdoff_request = 0;
            end
            stall = idle_on ? $urandom_range(0, 8) : 0;
            if (stall != 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_hashes.size() == 0)
            begin
                $error("digest: no hash expected, actual %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want_hash = expected_hashes.pop_front();
                if (m_axis_tdata !== want_hash)
                begin
                    $error("digest: expected %h, actual %h", want_hash, m_axis_tdata);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_KEY_LOW;
        cfg_data = 64'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 72'd0;
        s_axis_tlast = 1'b0;
        key0 = 64'd0;
        key1 = 64'd0;
        variant_code = VAR_2_4;
        reload_from_key();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_variants();
        test_config_abort();
        test_random_messages();
        test_backpressure();

        wait_idle();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
rtl/siph_pkg.sv
rtl/siph_round.sv
rtl/siphash_keyed_hash_core.sv
tb/sv/siphash_keyed_hash_core_test.sv
